[hw/rtl/i2r_pkg.sv]
// Shared types, constants and tables for the integer to Roman numeral unit.
// Holds the microcode program, the digit pattern tables and the symbol codes.
// No dependencies.
package i2r_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned CharW  = 7;
  localparam int unsigned DigitW = 4;
  localparam int unsigned RemW   = 10;
  localparam int unsigned UpcW   = 4;
  localparam int unsigned KW     = 2;
  localparam int unsigned LenW   = 3;

  localparam logic [ValueW-1:0] ValueMax = 12'd3999;

  // ASCII codes of the numeral symbols
  localparam logic [CharW-1:0] CharNone = 7'h00;
  localparam logic [CharW-1:0] CharI    = 7'h49;
  localparam logic [CharW-1:0] CharV    = 7'h56;
  localparam logic [CharW-1:0] CharX    = 7'h58;
  localparam logic [CharW-1:0] CharL    = 7'h4C;
  localparam logic [CharW-1:0] CharC    = 7'h43;
  localparam logic [CharW-1:0] CharD    = 7'h44;
  localparam logic [CharW-1:0] CharM    = 7'h4D;

  // Microcode addresses that are jump targets
  localparam logic [UpcW-1:0] UpcLoad = 4'd0;
  localparam logic [UpcW-1:0] UpcErr  = 4'd8;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DIV1000,
    OP_DIV100,
    OP_DIV10,
    OP_EMIT,
    OP_ERR
  } op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_BAD
  } jmp_t;

  typedef enum logic [1:0] {
    POS_UNITS,
    POS_TENS,
    POS_HUNDREDS,
    POS_THOUSANDS
  } pos_t;

  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_t;

  // One control word of the program
  typedef struct packed {
    op_t             op;
    pos_t            pos;
    jmp_t            jmp;
    logic [UpcW-1:0] target;
  } ucw_t;

  // Status from the datapath back to the sequencer
  typedef struct packed {
    logic done;  // current step finished
    logic bad;   // incoming value lies outside 1..3999
  } dp_stat_t;

  // Program: load, split into decimal digits, emit each position, or flag error
  function automatic ucw_t ucode_rom(input logic [UpcW-1:0] addr);
    ucw_t w;
    unique case (addr)
      4'd0:    w = '{op: OP_LOAD,    pos: POS_UNITS,     jmp: JMP_BAD,    target: UpcErr};
      4'd1:    w = '{op: OP_DIV1000, pos: POS_UNITS,     jmp: JMP_NONE,   target: UpcLoad};
      4'd2:    w = '{op: OP_DIV100,  pos: POS_UNITS,     jmp: JMP_NONE,   target: UpcLoad};
      4'd3:    w = '{op: OP_DIV10,   pos: POS_UNITS,     jmp: JMP_NONE,   target: UpcLoad};
      4'd4:    w = '{op: OP_EMIT,    pos: POS_THOUSANDS, jmp: JMP_NONE,   target: UpcLoad};
      4'd5:    w = '{op: OP_EMIT,    pos: POS_HUNDREDS,  jmp: JMP_NONE,   target: UpcLoad};
      4'd6:    w = '{op: OP_EMIT,    pos: POS_TENS,      jmp: JMP_NONE,   target: UpcLoad};
      4'd7:    w = '{op: OP_EMIT,    pos: POS_UNITS,     jmp: JMP_ALWAYS, target: UpcLoad};
      4'd8:    w = '{op: OP_ERR,     pos: POS_UNITS,     jmp: JMP_ALWAYS, target: UpcLoad};
      default: w = '{op: OP_LOAD,    pos: POS_UNITS,     jmp: JMP_ALWAYS, target: UpcLoad};
    endcase
    return w;
  endfunction

  // Number of characters in the pattern of one decimal digit
  function automatic logic [LenW-1:0] pat_len(input logic [DigitW-1:0] d);
    logic [LenW-1:0] n;
    unique case (d)
      4'd0:    n = 3'd0;
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Symbol at character k of a digit's pattern
  function automatic sym_t pat_sym(input logic [DigitW-1:0] d, input logic [KW-1:0] k);
    sym_t s;
    s = SYM_ONE;
    unique case (d) inside
      4'd4:         s = (k == 2'd0) ? SYM_ONE : SYM_FIVE;
      4'd9:         s = (k == 2'd0) ? SYM_ONE : SYM_TEN;
      [4'd5:4'd8]:  s = (k == 2'd0) ? SYM_FIVE : SYM_ONE;
      default:      s = SYM_ONE;
    endcase
    return s;
  endfunction

  // ASCII code of a symbol at a decimal position
  function automatic logic [CharW-1:0] sym_char(input pos_t p, input sym_t s);
    logic [CharW-1:0] c;
    c = CharNone;
    unique case (p)
      POS_UNITS:     c = (s == SYM_ONE) ? CharI : (s == SYM_FIVE) ? CharV : CharX;
      POS_TENS:      c = (s == SYM_ONE) ? CharX : (s == SYM_FIVE) ? CharL : CharC;
      POS_HUNDREDS:  c = (s == SYM_ONE) ? CharC : (s == SYM_FIVE) ? CharD : CharM;
      POS_THOUSANDS: c = (s == SYM_ONE) ? CharM : CharNone;
      default:       c = CharNone;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/i2r_sequencer.sv]
// Microcode sequencer: program counter and jump logic over the control ROM.
// Depends on i2r_pkg (control word type, program table).
module i2r_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  i2r_pkg::dp_stat_t  stat,
  output i2r_pkg::ucw_t      ctrl
);
  import i2r_pkg::*;

  logic [UpcW-1:0] upc;
  logic [UpcW-1:0] upc_next;
  logic            taken;

  // Fetch the control word and pick the next address
  always_comb begin
    ctrl     = ucode_rom(upc);
    taken    = (ctrl.jmp == JMP_ALWAYS) || ((ctrl.jmp == JMP_BAD) && stat.bad);
    upc_next = upc;
    if (stat.done) begin
      upc_next = taken ? ctrl.target : upc + UpcW'(1);
    end
  end

  // Hold the program counter; restart at the load step on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UpcLoad;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

[hw/rtl/i2r_datapath.sv]
// Datapath: value capture, digit split by reciprocal multiply, character output register.
// Depends on i2r_pkg (types, pattern tables, symbol codes).
module i2r_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  i2r_pkg::ucw_t                   ctrl,
  output i2r_pkg::dp_stat_t               stat,
  input  logic [i2r_pkg::ValueW-1:0]      value,
  input  logic                            item_valid,
  output logic                            item_ready,
  output logic [i2r_pkg::CharW-1:0]       char_code,
  output logic                            last,
  output logic                            out_of_range,
  output logic                            char_valid,
  input  logic                            char_ready
);
  import i2r_pkg::*;

  logic [ValueW-1:0] val_hold;
  logic [RemW-1:0]   rem;
  logic [DigitW-1:0] d3, d2, d1, d0;
  logic [KW-1:0]     k;

  logic [24:0]       prod1000;
  logic [16:0]       prod100;
  logic [14:0]       prod10;
  logic [1:0]        q1000;
  logic [DigitW-1:0] q100;
  logic [DigitW-1:0] q10;
  logic [ValueW-1:0] rem1000;
  logic [RemW-1:0]   rem100;
  logic [6:0]        rem10;

  logic [DigitW-1:0] dig;
  logic              lower_zero;
  logic [LenW-1:0]   len;
  logic              k_last;
  logic              slot_free;
  logic              fire_emit;
  logic              fire_err;
  logic [CharW-1:0]  emit_char;

  // Split the value into digits with reciprocal multiplies
  always_comb begin
    prod1000 = {13'd0, val_hold} * 25'd4195;
    q1000    = prod1000[23:22];
    rem1000  = val_hold - ({10'd0, q1000} * 12'd1000);
    prod100  = {7'd0, rem} * 17'd41;
    q100     = prod100[15:12];
    rem100   = rem - ({6'd0, q100} * 10'd100);
    prod10   = {8'd0, rem[6:0]} * 15'd205;
    q10      = prod10[14:11];
    rem10    = rem[6:0] - ({3'd0, q10} * 7'd10);
  end

  // Select the digit of the current position and its pattern
  always_comb begin
    unique case (ctrl.pos)
      POS_THOUSANDS: begin
        dig        = d3;
        lower_zero = (d2 == '0) && (d1 == '0) && (d0 == '0);
      end
      POS_HUNDREDS: begin
        dig        = d2;
        lower_zero = (d1 == '0) && (d0 == '0);
      end
      POS_TENS: begin
        dig        = d1;
        lower_zero = (d0 == '0);
      end
      default: begin
        dig        = d0;
        lower_zero = 1'b1;
      end
    endcase
    len       = pat_len(dig);
    k_last    = ({1'b0, k} == (len - 3'd1));
    emit_char = sym_char(ctrl.pos, pat_sym(dig, k));
  end

  // Step handshake with the sequencer and the input channel
  always_comb begin
    slot_free  = !char_valid || char_ready;
    fire_emit  = (ctrl.op == OP_EMIT) && slot_free && (len != '0);
    fire_err   = (ctrl.op == OP_ERR) && slot_free;
    item_ready = (ctrl.op == OP_LOAD);
    stat.bad   = (value == '0) || (value > ValueMax);
    unique case (ctrl.op)
      OP_LOAD:  stat.done = item_valid;
      OP_EMIT:  stat.done = (len == '0) || (slot_free && k_last);
      OP_ERR:   stat.done = slot_free;
      default:  stat.done = 1'b1;
    endcase
  end

  // Capture value and digits
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (item_valid) begin
          val_hold <= value;
        end
      end
      OP_DIV1000: begin
        d3  <= {2'd0, q1000};
        rem <= rem1000[RemW-1:0];
      end
      OP_DIV100: begin
        d2  <= q100;
        rem <= rem100;
      end
      OP_DIV10: begin
        d1 <= q10;
        d0 <= rem10[DigitW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Advance the character index within a digit's pattern
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (fire_emit) begin
      k <= k_last ? '0 : k + KW'(1);
    end
  end

  // Output register: load on a new character, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (fire_emit || fire_err) begin
      char_valid <= 1'b1;
    end else if (char_ready) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_err) begin
      char_code    <= CharNone;
      last         <= 1'b1;
      out_of_range <= 1'b1;
    end else if (fire_emit) begin
      char_code    <= emit_char;
      last         <= k_last && lower_zero;
      out_of_range <= 1'b0;
    end
  end

endmodule

[hw/rtl/integer_to_roman_numeral_unit.sv]
// Integer to Roman numeral unit: top level joining the sequencer and the datapath.
// Depends on i2r_pkg, i2r_sequencer and i2r_datapath.
//
// Usage:
//   Input channel (value, item_valid, item_ready) takes one 12-bit integer per
//   transaction. Output channel (char_code, last, out_of_range, char_valid,
//   char_ready) returns one ASCII numeral character per transaction, with last
//   set on the final character of the value's numeral.
//   A value of 0 or above 3999 yields a single transaction with char_code 0,
//   last 1 and out_of_range 1.
//   Sequence: one value at a time. The microcoded program loads the value, then
//   splits it into decimal digits by reciprocal multiplies (thousands, then
//   hundreds, then tens and units), then emits the characters of each position
//   in turn, thousands first; a zero digit passes without a character. An
//   invalid value goes from the load step straight to the error step.
//   item_ready is high only while the program sits at its load step; the last
//   character of the previous value may still wait in the output register.
//   Reset (rst, synchronous) returns the program to the load step and empties
//   the output register. When the receiver stalls, the program holds at its
//   current character until the output register frees up.
module integer_to_roman_numeral_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [i2r_pkg::ValueW-1:0] value,
  input  logic                       item_valid,
  output logic                       item_ready,
  output logic [i2r_pkg::CharW-1:0]  char_code,
  output logic                       last,
  output logic                       out_of_range,
  output logic                       char_valid,
  input  logic                       char_ready
);
  import i2r_pkg::*;

  ucw_t     ctrl;
  dp_stat_t stat;

  // Control program
  i2r_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Digit split and character output
  i2r_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .value        (value),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .char_code    (char_code),
    .last         (last),
    .out_of_range (out_of_range),
    .char_valid   (char_valid),
    .char_ready   (char_ready)
  );

endmodule

[hw/rtl/i2r_checker.sv]
// Port-level checks for the integer to Roman numeral unit, bound to its top level.
// Depends on i2r_pkg (symbol codes) and integer_to_roman_numeral_unit.
module i2r_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input logic [i2r_pkg::CharW-1:0]  char_code,
  input logic                       last,
  input logic                       out_of_range,
  input logic                       char_valid,
  input logic                       char_ready
);
  import i2r_pkg::*;

  // Stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid && $stable(char_code) && $stable(last)
      && $stable(out_of_range))
    else $error("output transaction changed while stalled");

  // Error result is flagged as last and carries a null character
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    char_valid && out_of_range |-> last && (char_code == CharNone))
    else $error("error transaction malformed");

  // Valid results carry only numeral symbols
  a_sym: assert property (@(posedge clk) disable iff (rst)
    char_valid && !out_of_range |-> (char_code == CharM) || (char_code == CharD)
      || (char_code == CharC) || (char_code == CharL) || (char_code == CharX)
      || (char_code == CharV) || (char_code == CharI))
    else $error("non-numeral character emitted");

  // One value at a time: no input taken right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input taken while a value is in progress");

endmodule

bind integer_to_roman_numeral_unit i2r_checker u_chk (.*);
